// ----- hw/rtl/dss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types, codes and reset values of the drill station sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    // sensor bit positions
    localparam int S_TABLEP = 0;
    localparam int S_DRILLP = 1;
    localparam int S_TESTP  = 2;
    localparam int S_TOP    = 3;
    localparam int S_BOTTOM = 4;
    localparam int S_POS    = 5;
    localparam int S_PASS   = 6;

    // actuator bit positions
    localparam int A_MOTOR  = 0;
    localparam int A_TABLE  = 1;
    localparam int A_DOWN   = 2;
    localparam int A_UP     = 3;
    localparam int A_CLAMP  = 4;
    localparam int A_TESTER = 5;
    localparam int A_EJECT  = 6;

    typedef enum logic [2:0] {
        PH_RAISE, PH_EMPTY, PH_ROTATE, PH_PROCESS, PH_HALTED
    } t_phase;

    typedef enum logic [2:0] {
        TB_IDLE, TB_LEAVE, TB_ARRIVE, TB_SETTLE, TB_DONE
    } t_tb_step;

    typedef enum logic [3:0] {
        DR_IDLE, DR_RAISE, DR_LOWER, DR_DWELL, DR_LIFT, DR_DONE
    } t_dr_step;

    typedef enum logic [2:0] {
        TS_IDLE, TS_POLL, TS_RETRACT, TS_DONE
    } t_ts_step;

    typedef enum logic [1:0] {
        EJ_IDLE, EJ_ON, EJ_DONE
    } t_ej_step;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EJECT, CFG_POLL, CFG_DWELL, CFG_SETTLE, CFG_TPOLLS, CFG_RETRACT
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] eject;
        logic [15:0] poll;
        logic [15:0] dwell;
        logic [15:0] settle;
        logic [3:0]  tpolls;
        logic [15:0] retract;
    } t_cfg;

    typedef struct packed {
        t_phase     phase;
        t_tb_step   tb;
        t_dr_step   dr;
        t_ts_step   ts;
        t_ej_step   ej;
        logic [3:0] poll_cnt;
        logic       reject;
        logic       drill_ok;
        logic       pwid;
        logic       init_rep;
        logic [6:0] act;
    } t_state;

    localparam t_cfg CFG_RST = '{
        eject:   16'd400,
        poll:    16'd50,
        dwell:   16'd300,
        settle:  16'd100,
        tpolls:  4'd5,
        retract: 16'd100
    };

    localparam t_state STATE_RST = '{
        phase:    PH_RAISE,
        tb:       TB_IDLE,
        dr:       DR_IDLE,
        ts:       TS_IDLE,
        ej:       EJ_IDLE,
        poll_cnt: 4'd0,
        reject:   1'b0,
        drill_ok: 1'b0,
        pwid:     1'b0,
        init_rep: 1'b0,
        act:      7'd0
    };

endpackage
`default_nettype wire

// ----- hw/rtl/dss_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dss_cfg_regs
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dss_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [dss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dss_pkg::t_cfg                       o_cfg
);
    import dss_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_EJECT:   n_cfg.eject   = i_cfg_data;
                CFG_POLL:    n_cfg.poll    = i_cfg_data;
                CFG_DWELL:   n_cfg.dwell   = i_cfg_data;
                CFG_SETTLE:  n_cfg.settle  = i_cfg_data;
                CFG_TPOLLS:  n_cfg.tpolls  = i_cfg_data[3:0];
                CFG_RETRACT: n_cfg.retract = i_cfg_data;
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- hw/rtl/dss_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dss_step
// Next-state logic for one tick: main phase, table, driller, tester and
// ejector sub-machines with their wait timers.
// ----------------------------------------------------------------------------
module dss_step #(
    parameter int TIMER_BITS = dss_pkg::TIMER_BITS_DEF
) (
    input  wire dss_pkg::t_cfg                i_cfg,
    input  wire dss_pkg::t_state              i_state,
    input  wire logic [3:0][TIMER_BITS-1:0]   i_timers,
    input  wire logic [6:0]                   i_sensors,
    input  wire logic                         i_link_fault,
    output dss_pkg::t_state                   o_state,
    output logic      [3:0][TIMER_BITS-1:0]   o_timers
);
    import dss_pkg::*;

    localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    function automatic logic [TIMER_BITS:0] wait_fire(
        input logic [TIMER_BITS-1:0] tmr,
        input logic [15:0]           target
    );
        logic [CW-1:0]         tmax;
        logic [CW-1:0]         tg;
        logic [TIMER_BITS-1:0] nt;
        logic                  fire;
        tmax = CW'({TIMER_BITS{1'b1}});
        tg   = CW'(target);
        if (tg > tmax) tg = tmax;
        if (tg == '0) tg = CW'(1);
        nt = tmr;
        if (tmr != {TIMER_BITS{1'b1}}) nt = tmr + TIMER_BITS'(1);
        fire = (CW'(nt) >= tg);
        if (fire) nt = '0;
        return {fire, nt};
    endfunction

    function automatic void table_run(
        inout t_state                st,
        inout logic [TIMER_BITS-1:0] tmr,
        input t_cfg                  cfg,
        input logic [6:0]            s
    );
        logic [TIMER_BITS:0] w;
        w = '0;
        if (st.tb == TB_LEAVE) begin
            w   = wait_fire(tmr, cfg.poll);
            tmr = w[TIMER_BITS-1:0];
            if (w[TIMER_BITS] && !s[S_POS]) begin
                st.act[A_TABLE] = 1'b0;
                st.tb = TB_ARRIVE;
            end
        end else if (st.tb == TB_ARRIVE) begin
            w   = wait_fire(tmr, cfg.poll);
            tmr = w[TIMER_BITS-1:0];
            if (w[TIMER_BITS] && s[S_POS]) st.tb = TB_SETTLE;
        end else if (st.tb == TB_SETTLE) begin
            w   = wait_fire(tmr, cfg.settle);
            tmr = w[TIMER_BITS-1:0];
            if (w[TIMER_BITS]) st.tb = TB_DONE;
        end
    endfunction

    function automatic void driller_run(
        inout t_state                st,
        inout logic [TIMER_BITS-1:0] tmr,
        input t_cfg                  cfg,
        input logic [6:0]            s
    );
        logic [TIMER_BITS:0] w;
        w = '0;
        if (st.dr == DR_RAISE) begin
            w   = wait_fire(tmr, cfg.poll);
            tmr = w[TIMER_BITS-1:0];
            if (w[TIMER_BITS] && s[S_TOP]) begin
                st.act[A_UP]    = 1'b0;
                st.act[A_DOWN]  = 1'b1;
                st.act[A_CLAMP] = 1'b1;
                st.act[A_MOTOR] = 1'b1;
                st.dr = DR_LOWER;
            end
        end else if (st.dr == DR_LOWER) begin
            w   = wait_fire(tmr, cfg.poll);
            tmr = w[TIMER_BITS-1:0];
            if (w[TIMER_BITS] && s[S_BOTTOM]) begin
                st.act[A_DOWN] = 1'b0;
                st.dr = DR_DWELL;
            end
        end else if (st.dr == DR_DWELL) begin
            w   = wait_fire(tmr, cfg.dwell);
            tmr = w[TIMER_BITS-1:0];
            if (w[TIMER_BITS]) begin
                st.act[A_UP] = 1'b1;
                st.dr = DR_LIFT;
            end
        end else if (st.dr == DR_LIFT) begin
            w   = wait_fire(tmr, cfg.poll);
            tmr = w[TIMER_BITS-1:0];
            if (w[TIMER_BITS] && s[S_TOP]) begin
                st.act[A_UP]    = 1'b0;
                st.act[A_MOTOR] = 1'b0;
                st.act[A_CLAMP] = 1'b0;
                st.dr = DR_DONE;
            end
        end
    endfunction

    function automatic void tester_run(
        inout t_state                st,
        inout logic [TIMER_BITS-1:0] tmr,
        input t_cfg                  cfg,
        input logic [6:0]            s
    );
        logic [TIMER_BITS:0] w;
        w = '0;
        if (st.ts == TS_POLL) begin
            w   = wait_fire(tmr, cfg.poll);
            tmr = w[TIMER_BITS-1:0];
            if (w[TIMER_BITS]) begin
                if (st.poll_cnt != 4'd15) st.poll_cnt = st.poll_cnt + 4'd1;
                if (s[S_PASS]) st.reject = 1'b0;
                else if (st.poll_cnt < cfg.tpolls) st.reject = 1'b1;
                if (s[S_PASS] || (st.poll_cnt >= cfg.tpolls)) begin
                    st.act[A_TESTER] = 1'b0;
                    st.ts = TS_RETRACT;
                end
            end
        end else if (st.ts == TS_RETRACT) begin
            w   = wait_fire(tmr, cfg.retract);
            tmr = w[TIMER_BITS-1:0];
            if (w[TIMER_BITS]) begin
                st.drill_ok = !st.reject;
                st.ts = TS_DONE;
            end
        end
    endfunction

    function automatic void ejector_run(
        inout t_state                st,
        inout logic [TIMER_BITS-1:0] tmr,
        input t_cfg                  cfg
    );
        logic [TIMER_BITS:0] w;
        w = '0;
        if (st.ej == EJ_ON) begin
            w   = wait_fire(tmr, cfg.eject);
            tmr = w[TIMER_BITS-1:0];
            if (w[TIMER_BITS]) begin
                st.act[A_EJECT] = 1'b0;
                st.ej = EJ_DONE;
            end
        end
    endfunction

    function automatic void process_start(
        inout t_state                     st,
        inout logic [3:0][TIMER_BITS-1:0] tm,
        input logic [6:0]                 s
    );
        if (st.pwid) begin
            st.act[A_EJECT] = 1'b1;
            tm[3] = '0;
            st.ej = EJ_ON;
        end
        if (s[S_TESTP]) begin
            st.act[A_TESTER] = 1'b1;
            tm[2] = '0;
            st.poll_cnt = 4'd0;
            st.reject = 1'b0;
            st.ts = TS_POLL;
        end
        if (s[S_DRILLP] && st.drill_ok) begin
            st.act[A_UP] = 1'b1;
            tm[1] = '0;
            st.dr = DR_RAISE;
        end
        st.phase = PH_PROCESS;
    endfunction

    t_state                     st;
    logic [3:0][TIMER_BITS-1:0] tm;
    logic [TIMER_BITS:0]        w;
    logic                       any_p;

    assign any_p = i_sensors[S_TABLEP] | i_sensors[S_DRILLP] | i_sensors[S_TESTP];

    always_comb begin
        st = i_state;
        tm = i_timers;
        w  = '0;
        if (i_link_fault || (st.phase == PH_HALTED)) begin
            st.phase = PH_HALTED;
        end else begin
            case (st.phase)
                PH_RAISE: begin
                    st.act[A_UP] = 1'b1;
                    w     = wait_fire(tm[0], i_cfg.poll);
                    tm[0] = w[TIMER_BITS-1:0];
                    if (w[TIMER_BITS] && i_sensors[S_TOP]) begin
                        st.init_rep = any_p;
                        st.phase = PH_EMPTY;
                    end
                end
                PH_EMPTY: begin
                    if ((st.tb == TB_IDLE) && (st.ej == EJ_IDLE)) begin
                        if (st.init_rep) begin
                            st.pwid = i_sensors[S_DRILLP];
                            st.init_rep = any_p;
                            st.act[A_TABLE] = 1'b1;
                            tm[0] = '0;
                            st.tb = TB_LEAVE;
                        end else begin
                            st.phase = PH_ROTATE;
                        end
                    end else begin
                        ejector_run(st, tm[3], i_cfg);
                        if (st.ej == EJ_DONE) st.ej = EJ_IDLE;
                        table_run(st, tm[0], i_cfg, i_sensors);
                        if (st.tb == TB_DONE) begin
                            st.tb = TB_IDLE;
                            if (st.pwid) begin
                                st.act[A_EJECT] = 1'b1;
                                tm[3] = '0;
                                st.ej = EJ_ON;
                            end
                        end
                    end
                end
                PH_ROTATE: begin
                    if (st.tb == TB_IDLE) begin
                        st.pwid = i_sensors[S_DRILLP];
                        if (any_p) begin
                            st.act[A_TABLE] = 1'b1;
                            tm[0] = '0;
                            st.tb = TB_LEAVE;
                        end else begin
                            process_start(st, tm, i_sensors);
                        end
                    end else begin
                        table_run(st, tm[0], i_cfg, i_sensors);
                        if (st.tb == TB_DONE) begin
                            st.tb = TB_IDLE;
                            process_start(st, tm, i_sensors);
                        end
                    end
                end
                PH_PROCESS: begin
                    ejector_run(st, tm[3], i_cfg);
                    tester_run(st, tm[2], i_cfg, i_sensors);
                    driller_run(st, tm[1], i_cfg, i_sensors);
                    if (((st.ej == EJ_IDLE) || (st.ej == EJ_DONE)) &&
                        ((st.ts == TS_IDLE) || (st.ts == TS_DONE)) &&
                        ((st.dr == DR_IDLE) || (st.dr == DR_DONE))) begin
                        st.ej = EJ_IDLE;
                        st.ts = TS_IDLE;
                        st.dr = DR_IDLE;
                        st.phase = PH_ROTATE;
                    end
                end
                default: begin
                    st = i_state;
                end
            endcase
        end
    end

    assign o_state  = st;
    assign o_timers = tm;

endmodule
`default_nettype wire

// ----- hw/rtl/drill_station_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// drill_station_sequencer
// Tick-driven sequencer of a drill station: one sensor word in, one
// actuator and status word out.
// ----------------------------------------------------------------------------
// data path: input register, step logic, then the state/result registers
// throughput: one word per cycle unless i_out_ready stalls it, set by the
//   single-pass step logic between the input and state/result registers
// reset: synchronous active low; clears the sequencer state, timers and
//   handshake stages, and loads the timing registers with their defaults
module drill_station_sequencer #(
    parameter int TIMER_BITS = dss_pkg::TIMER_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [dss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [6:0]                     i_sensors,
    input  wire logic                           i_link_fault,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [7:0]                          o_actuators,
    output logic [2:0]                          o_phase,
    output logic                                o_drill_next,
    output logic                                o_halted
);
    import dss_pkg::*;

    t_cfg                       cfg;
    t_state                     r_state;
    t_state                     n_state;
    logic [3:0][TIMER_BITS-1:0] r_timers;
    logic [3:0][TIMER_BITS-1:0] n_timers;

    logic       r_in_vld;
    logic [6:0] r_sens;
    logic       r_fault;
    logic       r_out_vld;
    logic [6:0] r_act;
    t_phase     r_phase;
    logic       r_dok;
    logic       adv;

    dss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dss_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_timers     (r_timers),
        .i_sensors    (r_sens),
        .i_link_fault (r_fault),
        .o_state      (n_state),
        .o_timers     (n_timers)
    );

    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= STATE_RST;
            r_timers  <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_state   <= n_state;
                r_timers  <= n_timers;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_sens  <= i_sensors;
            r_fault <= i_link_fault;
        end
        if (adv) begin
            r_act   <= n_state.act;
            r_phase <= n_state.phase;
            r_dok   <= n_state.drill_ok;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_actuators  = {1'b0, r_act};
    assign o_phase      = r_phase;
    assign o_drill_next = r_dok;
    assign o_halted     = (r_phase == PH_HALTED);

endmodule
`default_nettype wire

// ----- sim/drill_station_sequencer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drill_station_sequencer_test
// Self-checking bench for the drill station sequencer. Tick words are sent
// with random gaps, and result words are taken with random stalls. A
// cycle-free model of the station computes the expected result word for each
// accepted tick and compares it field by field. Sensor words mostly follow
// what the sequencer waits for, so that every phase and sub-machine is
// reached under many timing settings. The run ends with a link fault.
// ----------------------------------------------------------------------------
module drill_station_sequencer_test;
    import dss_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    typedef struct packed {
        logic [7:0] actuators;
        logic [2:0] phase;
        logic       drill_next;
        logic       halted;
    } t_station_word;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  tick_valid = 1'b0;
    logic                  tick_ready;
    logic [6:0]            tick_sensors = '0;
    logic                  tick_fault = 1'b0;
    logic                  word_valid;
    logic                  word_ready = 1'b0;
    logic [7:0]            word_actuators;
    logic [2:0]            word_phase;
    logic                  word_drill_next;
    logic                  word_halted;

    drill_station_sequencer u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (tick_valid),
        .o_in_ready   (tick_ready),
        .i_sensors    (tick_sensors),
        .i_link_fault (tick_fault),
        .o_out_valid  (word_valid),
        .i_out_ready  (word_ready),
        .o_actuators  (word_actuators),
        .o_phase      (word_phase),
        .o_drill_next (word_drill_next),
        .o_halted     (word_halted)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // station model state
    t_cfg          timing;
    t_phase        cur_phase;
    t_tb_step      tbl_step;
    t_dr_step      drl_step;
    t_ts_step      tst_step;
    t_ej_step      ejc_step;
    logic [15:0]   unit_tmr [4];
    logic [3:0]    polls_done;
    logic          reject_flag;
    logic          verdict_ok;
    logic          drill_had_piece;
    logic          empty_again;
    logic [6:0]    act_bits;

    t_station_word pending_outputs [$];
    int            fails = 0;
    int            checked = 0;
    int            settings = 0;
    bit            valid_held = 0;
    bit            gaps_on = 1;
    bit            stalls_on = 1;
    int            stall_left = 0;

    task automatic reset_station();
        timing = '{eject: 16'd400, poll: 16'd50, dwell: 16'd300, settle: 16'd100,
                   tpolls: 4'd5, retract: 16'd100};
        cur_phase = PH_RAISE;
        tbl_step = TB_IDLE;
        drl_step = DR_IDLE;
        tst_step = TS_IDLE;
        ejc_step = EJ_IDLE;
        for (int i = 0; i < 4; i++) unit_tmr[i] = '0;
        polls_done = '0;
        reject_flag = 1'b0;
        verdict_ok = 1'b0;
        drill_had_piece = 1'b0;
        empty_again = 1'b0;
        act_bits = '0;
    endtask

    function automatic bit tick_wait(int u, logic [15:0] target);
        logic [16:0] lim;
        lim = (target == 16'd0) ? 17'd1 : {1'b0, target};
        if (unit_tmr[u] != 16'hFFFF) unit_tmr[u] = unit_tmr[u] + 16'd1;
        if ({1'b0, unit_tmr[u]} >= lim) begin
            unit_tmr[u] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic any_piece(logic [6:0] s);
        return s[S_TABLEP] | s[S_DRILLP] | s[S_TESTP];
    endfunction

    function automatic void table_advance(logic [6:0] s);
        bit fired;
        case (tbl_step)
            TB_LEAVE: begin
                fired = tick_wait(0, timing.poll);
                if (fired && !s[S_POS]) begin
                    act_bits[A_TABLE] = 1'b0;
                    tbl_step = TB_ARRIVE;
                end
            end
            TB_ARRIVE: begin
                fired = tick_wait(0, timing.poll);
                if (fired && s[S_POS]) tbl_step = TB_SETTLE;
            end
            TB_SETTLE: begin
                if (tick_wait(0, timing.settle)) tbl_step = TB_DONE;
            end
            default: ;
        endcase
    endfunction

    function automatic void driller_advance(logic [6:0] s);
        bit fired;
        case (drl_step)
            DR_RAISE: begin
                fired = tick_wait(1, timing.poll);
                if (fired && s[S_TOP]) begin
                    act_bits[A_UP] = 1'b0;
                    act_bits[A_DOWN] = 1'b1;
                    act_bits[A_CLAMP] = 1'b1;
                    act_bits[A_MOTOR] = 1'b1;
                    drl_step = DR_LOWER;
                end
            end
            DR_LOWER: begin
                fired = tick_wait(1, timing.poll);
                if (fired && s[S_BOTTOM]) begin
                    act_bits[A_DOWN] = 1'b0;
                    drl_step = DR_DWELL;
                end
            end
            DR_DWELL: begin
                if (tick_wait(1, timing.dwell)) begin
                    act_bits[A_UP] = 1'b1;
                    drl_step = DR_LIFT;
                end
            end
            DR_LIFT: begin
                fired = tick_wait(1, timing.poll);
                if (fired && s[S_TOP]) begin
                    act_bits[A_UP] = 1'b0;
                    act_bits[A_MOTOR] = 1'b0;
                    act_bits[A_CLAMP] = 1'b0;
                    drl_step = DR_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void tester_advance(logic [6:0] s);
        case (tst_step)
            TS_POLL: begin
                if (tick_wait(2, timing.poll)) begin
                    if (polls_done != 4'd15) polls_done = polls_done + 4'd1;
                    if (s[S_PASS]) reject_flag = 1'b0;
                    else if (polls_done < timing.tpolls) reject_flag = 1'b1;
                    if (s[S_PASS] || polls_done >= timing.tpolls) begin
                        act_bits[A_TESTER] = 1'b0;
                        tst_step = TS_RETRACT;
                    end
                end
            end
            TS_RETRACT: begin
                if (tick_wait(2, timing.retract)) begin
                    verdict_ok = !reject_flag;
                    tst_step = TS_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void ejector_advance();
        if (ejc_step == EJ_ON && tick_wait(3, timing.eject)) begin
            act_bits[A_EJECT] = 1'b0;
            ejc_step = EJ_DONE;
        end
    endfunction

    function automatic void table_launch();
        act_bits[A_TABLE] = 1'b1;
        unit_tmr[0] = '0;
        tbl_step = TB_LEAVE;
    endfunction

    function automatic void ejector_launch();
        act_bits[A_EJECT] = 1'b1;
        unit_tmr[3] = '0;
        ejc_step = EJ_ON;
    endfunction

    function automatic void units_launch(logic [6:0] s);
        if (drill_had_piece) ejector_launch();
        if (s[S_TESTP]) begin
            act_bits[A_TESTER] = 1'b1;
            unit_tmr[2] = '0;
            polls_done = '0;
            reject_flag = 1'b0;
            tst_step = TS_POLL;
        end
        if (s[S_DRILLP] && verdict_ok) begin
            act_bits[A_UP] = 1'b1;
            unit_tmr[1] = '0;
            drl_step = DR_RAISE;
        end
        cur_phase = PH_PROCESS;
    endfunction

    function automatic t_station_word advance_station(logic [6:0] s, logic fault);
        t_station_word w;
        bit fired;
        if (fault || cur_phase == PH_HALTED) begin
            cur_phase = PH_HALTED;
        end else begin
            case (cur_phase)
                PH_RAISE: begin
                    act_bits[A_UP] = 1'b1;
                    fired = tick_wait(0, timing.poll);
                    if (fired && s[S_TOP]) begin
                        empty_again = any_piece(s);
                        cur_phase = PH_EMPTY;
                    end
                end
                PH_EMPTY: begin
                    if (tbl_step == TB_IDLE && ejc_step == EJ_IDLE) begin
                        if (empty_again) begin
                            drill_had_piece = s[S_DRILLP];
                            empty_again = any_piece(s);
                            table_launch();
                        end else begin
                            cur_phase = PH_ROTATE;
                        end
                    end else begin
                        ejector_advance();
                        if (ejc_step == EJ_DONE) ejc_step = EJ_IDLE;
                        table_advance(s);
                        if (tbl_step == TB_DONE) begin
                            tbl_step = TB_IDLE;
                            if (drill_had_piece) ejector_launch();
                        end
                    end
                end
                PH_ROTATE: begin
                    if (tbl_step == TB_IDLE) begin
                        drill_had_piece = s[S_DRILLP];
                        if (any_piece(s)) table_launch();
                        else units_launch(s);
                    end else begin
                        table_advance(s);
                        if (tbl_step == TB_DONE) begin
                            tbl_step = TB_IDLE;
                            units_launch(s);
                        end
                    end
                end
                default: begin
                    ejector_advance();
                    tester_advance(s);
                    driller_advance(s);
                    if ((ejc_step == EJ_IDLE || ejc_step == EJ_DONE) &&
                        (tst_step == TS_IDLE || tst_step == TS_DONE) &&
                        (drl_step == DR_IDLE || drl_step == DR_DONE)) begin
                        ejc_step = EJ_IDLE;
                        tst_step = TS_IDLE;
                        drl_step = DR_IDLE;
                        cur_phase = PH_ROTATE;
                    end
                end
            endcase
        end
        w.actuators = {1'b0, act_bits};
        w.phase = cur_phase;
        w.drill_next = verdict_ok;
        w.halted = (cur_phase == PH_HALTED);
        return w;
    endfunction

    // sensor word that mostly gives the running step what it waits for
    function automatic logic [6:0] station_sensors(int pass_pct);
        logic [6:0] s;
        s = 7'($urandom);
        s[S_PASS] = ($urandom_range(0, 99) < pass_pct);
        if ($urandom_range(0, 3) != 0) begin
            case (cur_phase)
                PH_RAISE: s[S_TOP] = 1'b1;
                PH_EMPTY, PH_ROTATE: begin
                    if (cur_phase == PH_EMPTY && $urandom_range(0, 1) == 1) begin
                        s[S_TABLEP] = 1'b0;
                        s[S_DRILLP] = 1'b0;
                        s[S_TESTP] = 1'b0;
                    end
                    if (tbl_step == TB_LEAVE) s[S_POS] = 1'b0;
                    else if (tbl_step == TB_ARRIVE) s[S_POS] = 1'b1;
                end
                PH_PROCESS: begin
                    if (drl_step == DR_RAISE || drl_step == DR_LIFT) s[S_TOP] = 1'b1;
                    else if (drl_step == DR_LOWER) s[S_BOTTOM] = 1'b1;
                end
                default: ;
            endcase
        end
        return s;
    endfunction

    function automatic int pick_idle(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic release_input();
        if (valid_held) begin
            tick_valid <= 1'b0;
            valid_held = 0;
        end
    endtask

    task automatic send_tick(input logic [6:0] s, input logic fault);
        int gap;
        gap = pick_idle(gaps_on);
        if (gap > 0) begin
            release_input();
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_sensors <= s;
        tick_fault <= fault;
        valid_held = 1;
        do @(posedge clk); while (!tick_ready);
        pending_outputs.push_back(advance_station(s, fault));
    endtask

    task automatic drain_results();
        release_input();
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_EJECT:   timing.eject = val;
            CFG_POLL:    timing.poll = val;
            CFG_DWELL:   timing.dwell = val;
            CFG_SETTLE:  timing.settle = val;
            CFG_TPOLLS:  timing.tpolls = val[3:0];
            CFG_RETRACT: timing.retract = val;
            default: ;
        endcase
    endtask

    task automatic program_timing(input logic [15:0] eject, input logic [15:0] poll,
                                  input logic [15:0] dwell, input logic [15:0] settle,
                                  input logic [15:0] tpolls, input logic [15:0] retract);
        drain_results();
        write_reg(CFG_EJECT, eject);
        write_reg(CFG_POLL, poll);
        write_reg(CFG_DWELL, dwell);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_TPOLLS, tpolls);
        write_reg(CFG_RETRACT, retract);
        settings++;
    endtask

    task automatic run_random(input int count, input int pass_pct);
        for (int i = 0; i < count; i++) send_tick(station_sensors(pass_pct), 1'b0);
    endtask

    task automatic check_word();
        t_station_word want;
        if (pending_outputs.size() == 0) begin
            $error("result word with nothing expected");
            fails++;
            return;
        end
        want = pending_outputs.pop_front();
        if (word_actuators !== want.actuators) begin
            $error("actuators: expected %h, got %h", want.actuators, word_actuators);
            fails++;
        end
        if (word_phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, word_phase);
            fails++;
        end
        if (word_drill_next !== want.drill_next) begin
            $error("drill_next: expected %b, got %b", want.drill_next, word_drill_next);
            fails++;
        end
        if (word_halted !== want.halted) begin
            $error("halted: expected %b, got %b", want.halted, word_halted);
            fails++;
        end
        checked++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            word_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (word_valid && word_ready) check_word();
            if (stall_left > 0) begin
                stall_left--;
                word_ready <= 1'b0;
            end else begin
                stall_left = pick_idle(stalls_on);
                word_ready <= (stall_left == 0);
            end
        end
    end

    // field extremes at reset timing, then a scripted init, rotation and test
    task automatic test_directed_edges();
        logic [6:0] script [18];
        send_tick(7'h00, 1'b0);
        send_tick(7'h7F, 1'b0);
        for (int b = 0; b < 7; b++) send_tick(7'(1 << b), 1'b0);
        program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd1);
        script = '{
            7'(1 << S_TOP) | 7'(1 << S_TABLEP), 7'(1 << S_DRILLP), 7'h00,
            7'(1 << S_POS), 7'h00, 7'h00, 7'h00, 7'h00, 7'(1 << S_POS), 7'h00,
            7'h00, 7'(1 << S_TESTP) | 7'(1 << S_DRILLP), 7'h00, 7'(1 << S_POS),
            7'(1 << S_TESTP) | 7'(1 << S_DRILLP), 7'h00, 7'h00, 7'h00
        };
        foreach (script[i]) send_tick(script[i], 1'b0);
    endtask

    task automatic test_fast_timing();
        gaps_on = 1;
        stalls_on = 1;
        program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        run_random(250, 50);
    endtask

    task automatic test_zero_registers();
        gaps_on = 0;
        stalls_on = 0;
        program_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(150, 50);
    endtask

    task automatic test_reject_verdicts();
        gaps_on = 1;
        stalls_on = 1;
        program_timing(16'd2, 16'd1, 16'd3, 16'd2, 16'd15, 16'd2);
        run_random(250, 15);
    endtask

    task automatic test_mixed_timing();
        for (int r = 0; r < 4; r++) begin
            gaps_on = 1'($urandom_range(0, 1));
            stalls_on = 1'($urandom_range(0, 1));
            program_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                           16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                           16'($urandom_range(0, 15)), 16'($urandom_range(1, 6)));
            if (r == 0) write_reg(CFG_IDX_SPARE, 16'($urandom));
            run_random(150, 50);
        end
    endtask

    // long targets leave the timers counting; short ones then fire at once
    task automatic test_saturated_registers();
        gaps_on = 1;
        stalls_on = 1;
        program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(150, 50);
        program_timing(16'd3, 16'd2, 16'd3, 16'd2, 16'd4, 16'd3);
        run_random(100, 50);
    endtask

    task automatic test_link_fault();
        gaps_on = 1;
        stalls_on = 1;
        run_random(5, 50);
        send_tick(station_sensors(50), 1'b1);
        for (int i = 0; i < 25; i++) send_tick(7'($urandom), 1'($urandom));
        program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        for (int i = 0; i < 5; i++) send_tick(7'($urandom), 1'b0);
    endtask

    initial begin
        reset_station();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_fast_timing();
        test_zero_registers();
        test_reject_verdicts();
        test_mixed_timing();
        test_saturated_registers();
        test_link_fault();
        drain_results();
        repeat (8) @(posedge clk);
        $display("summary: %0d result words checked over %0d timing settings", checked,
                 settings);
        $display("summary: directed edges, reject verdicts, saturated waits, fault halt");
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dss_pkg.sv
hw/rtl/dss_cfg_regs.sv
hw/rtl/dss_step.sv
hw/rtl/drill_station_sequencer.sv
sim/drill_station_sequencer_test.sv
